[rtl/cpr_pkg.sv]
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and constants for the cross outline transform
// Holds the sequencer states, command and register codes, the CORDIC
// request/response structs, the arctangent table and the corner pattern.
// ----------------------------------------------------------------------------
`default_nettype none

package cpr_pkg;

  localparam int SEGMENT_COUNT = 12;
  localparam int WORD_COUNT    = 4 * SEGMENT_COUNT;
  localparam int WORD_AW       = 6;
  localparam int ATAN_LEN      = 24;
  localparam int TRIG_BITS     = 30;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  typedef enum logic {
    CMD_REBUILD = 1'b0,
    CMD_MOVE    = 1'b1
  } cpr_cmd_e;

  typedef enum logic [1:0] {
    REG_HALF_WIDTH = 2'd0,
    REG_REACH      = 2'd1,
    REG_CENTER_X   = 2'd2,
    REG_CENTER_Y   = 2'd3
  } cpr_reg_e;

  // corner codes: plus w, minus w, plus l, minus l
  typedef enum logic [1:0] {
    CRN_PW = 2'd0,
    CRN_MW = 2'd1,
    CRN_PL = 2'd2,
    CRN_ML = 2'd3
  } cpr_corner_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD,
    ST_TRIG,
    ST_RD_X,
    ST_RD_Y,
    ST_MUL,
    ST_EMIT,
    ST_DRAIN
  } cpr_state_e;

  typedef struct packed {
    logic               start;
    logic signed [15:0] angle;
  } cpr_trig_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } cpr_trig_rsp_t;

  function automatic logic signed [31:0] atan_lut(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:    v = 32'sd536870912;
      5'd1:    v = 32'sd316933406;
      5'd2:    v = 32'sd167458907;
      5'd3:    v = 32'sd85004756;
      5'd4:    v = 32'sd42667331;
      5'd5:    v = 32'sd21354465;
      5'd6:    v = 32'sd10680862;
      5'd7:    v = 32'sd5340245;
      5'd8:    v = 32'sd2670163;
      5'd9:    v = 32'sd1335087;
      5'd10:   v = 32'sd667544;
      5'd11:   v = 32'sd333772;
      5'd12:   v = 32'sd166886;
      5'd13:   v = 32'sd83443;
      5'd14:   v = 32'sd41721;
      5'd15:   v = 32'sd20860;
      5'd16:   v = 32'sd10430;
      5'd17:   v = 32'sd5215;
      5'd18:   v = 32'sd2607;
      5'd19:   v = 32'sd1303;
      5'd20:   v = 32'sd651;
      5'd21:   v = 32'sd325;
      5'd22:   v = 32'sd162;
      5'd23:   v = 32'sd81;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  function automatic cpr_corner_e corner_lut(input logic [WORD_AW-1:0] k);
    cpr_corner_e c;
    case (k)
      6'd0:  c = CRN_MW;  6'd1:  c = CRN_PL;  6'd2:  c = CRN_PW;  6'd3:  c = CRN_PL;
      6'd4:  c = CRN_PW;  6'd5:  c = CRN_PL;  6'd6:  c = CRN_PW;  6'd7:  c = CRN_PW;
      6'd8:  c = CRN_PW;  6'd9:  c = CRN_PW;  6'd10: c = CRN_PL;  6'd11: c = CRN_PW;
      6'd12: c = CRN_PL;  6'd13: c = CRN_PW;  6'd14: c = CRN_PL;  6'd15: c = CRN_MW;
      6'd16: c = CRN_PL;  6'd17: c = CRN_MW;  6'd18: c = CRN_PW;  6'd19: c = CRN_MW;
      6'd20: c = CRN_PW;  6'd21: c = CRN_MW;  6'd22: c = CRN_PW;  6'd23: c = CRN_ML;
      6'd24: c = CRN_PW;  6'd25: c = CRN_ML;  6'd26: c = CRN_MW;  6'd27: c = CRN_ML;
      6'd28: c = CRN_MW;  6'd29: c = CRN_ML;  6'd30: c = CRN_MW;  6'd31: c = CRN_MW;
      6'd32: c = CRN_MW;  6'd33: c = CRN_MW;  6'd34: c = CRN_ML;  6'd35: c = CRN_MW;
      6'd36: c = CRN_ML;  6'd37: c = CRN_MW;  6'd38: c = CRN_ML;  6'd39: c = CRN_PW;
      6'd40: c = CRN_ML;  6'd41: c = CRN_PW;  6'd42: c = CRN_MW;  6'd43: c = CRN_PW;
      6'd44: c = CRN_MW;  6'd45: c = CRN_PW;  6'd46: c = CRN_MW;  6'd47: c = CRN_PL;
      default: c = CRN_PW;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/cross_polygon_rigid_transform.sv]
// ----------------------------------------------------------------------------
// cross_polygon_rigid_transform: twelve-segment cross outline with rigid motion
// Rebuilds the outline from configuration, or rotates and shifts it, then
// emits all twelve segments.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write arm_half_width, arm_reach, center_x, center_y
//   through cfg_valid_i/cfg_index_i/cfg_data_i; cfg_ready_o is always high.
//   Command: a request is taken when start is high and busy is low.
//   command_i = 0 rebuilds the outline, 1 rotates it about the origin by
//   turn_angle_i and adds (shift_x_i, shift_y_i).
//   Results: twelve segments, one per four words, each marked by a one-cycle
//   out_strobe_o; last_segment_o flags the twelfth. The receiver cannot stall.
// Sequence:
//   Rebuild: all 48 words are written from the configuration, then emitted.
//   Move: the CORDIC runs its rotation steps (capped at 24) for sine and
//   cosine, then each of 24 points is read, rotated through one 32x32
//   multiplier and written back, then the outline is emitted.
//   The emit rate is set by the single read port of the endpoint RAM.
//   busy is high from the request until the last segment is on the ports.
// Reset:
//   Configuration and control registers clear to zero and the stored outline reads as all zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module cross_polygon_rigid_transform
  import cpr_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               command_i,
  input  wire logic signed [31:0] shift_x_i,
  input  wire logic signed [31:0] shift_y_i,
  input  wire logic signed [15:0] turn_angle_i,
  output logic                    out_strobe_o,
  output logic [3:0]              segment_index_o,
  output logic signed [31:0]      begin_x_o,
  output logic signed [31:0]      begin_y_o,
  output logic signed [31:0]      end_x_o,
  output logic signed [31:0]      end_y_o,
  output logic                    last_segment_o
);

  localparam logic [WORD_AW-1:0] LAST_WORD  = WORD_AW'(WORD_COUNT - 1);
  localparam logic [WORD_AW-1:0] LAST_POINT = WORD_AW'(WORD_COUNT / 2 - 1);
  localparam logic [3:0]         LAST_SEG   = 4'(SEGMENT_COUNT - 1);
  localparam logic signed [64:0] HALF_LSB   = 65'sd1 <<< (TRIG_BITS - 1);

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // drop the Q2.30 fraction, add the shift, clamp
  function automatic logic signed [31:0] finish(input logic signed [64:0] acc,
                                                input logic signed [31:0] sh);
    logic signed [35:0] sum;
    sum = {acc[64], acc[64:TRIG_BITS]} + {{4{sh[31]}}, sh};
    return sat32(sum);
  endfunction

  // configuration registers
  logic signed [31:0] half_width_q, reach_q, center_x_q, center_y_q;

  // sequencer
  cpr_state_e         state_q, state_d;
  logic [WORD_AW-1:0] idx_q, idx_d;
  logic [2:0]         step_q, step_d;
  logic               live_q, live_d;

  // datapath registers
  logic signed [31:0] sx_q, sy_q, cos_q, sin_q, x_q, y_q, nx_q;
  logic signed [63:0] prod_q;
  logic signed [64:0] acc_q;

  // emit pipeline
  logic               rd_pend_q;
  logic [WORD_AW-1:0] rd_tag_q;
  logic               strobe_q;
  logic [3:0]         seg_q;
  logic               last_q;
  logic signed [31:0] bx_q, by_q, ex_q, ey_q;

  // memory and shared units
  logic               ram_we;
  logic [WORD_AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata, ram_rdata;
  logic signed [31:0] rd_word;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_d;
  logic signed [32:0] base;
  logic signed [35:0] build_sum;
  logic signed [31:0] center;
  cpr_trig_req_t      trig_req;
  cpr_trig_rsp_t      trig_rsp;
  logic               accept;

  assign busy        = state_q != ST_IDLE;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= '0;
      reach_q      <= '0;
      center_x_q   <= '0;
      center_y_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cpr_reg_e'(cfg_index_i))
        REG_HALF_WIDTH: half_width_q <= cfg_data_i;
        REG_REACH:      reach_q      <= cfg_data_i;
        REG_CENTER_X:   center_x_q   <= cfg_data_i;
        REG_CENTER_Y:   center_y_q   <= cfg_data_i;
        default:        half_width_q <= half_width_q;
      endcase
    end
  end

  cpr_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (trig_req),
    .rsp_o (trig_rsp)
  );

  cpr_ram #(
    .WIDTH(32),
    .DEPTH(WORD_COUNT)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // words never written since reset read as zero
  assign rd_word = live_q ? ram_rdata : 32'sd0;

  // rebuild coordinate for word idx_q
  always_comb begin
    case (corner_lut(idx_q))
      CRN_PW:  base = {half_width_q[31], half_width_q};
      CRN_MW:  base = -{half_width_q[31], half_width_q};
      CRN_PL:  base = {reach_q[31], reach_q};
      CRN_ML:  base = -{reach_q[31], reach_q};
      default: base = '0;
    endcase
  end
  assign center    = idx_q[0] ? center_y_q : center_x_q;
  assign build_sum = {{3{base[32]}}, base} + {{4{center[31]}}, center};

  // shared multiplier operand select
  assign mul_a  = (step_q == 3'd0 || step_q == 3'd2) ? x_q : y_q;
  assign mul_b  = (step_q == 3'd0 || step_q == 3'd3) ? cos_q : sin_q;
  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      step_q  <= '0;
      live_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      live_q  <= live_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    step_d         = step_q;
    live_d         = live_q;
    ram_we         = 1'b0;
    ram_waddr      = idx_q;
    ram_wdata      = sat32(build_sum);
    ram_raddr      = idx_q;
    trig_req.start = 1'b0;
    trig_req.angle = turn_angle_i;
    case (state_q)
      ST_IDLE: begin
        idx_d  = '0;
        step_d = '0;
        if (accept) begin
          if (cpr_cmd_e'(command_i) == CMD_MOVE) begin
            trig_req.start = 1'b1;
            state_d        = ST_TRIG;
          end else begin
            state_d = ST_BUILD;
          end
        end
      end
      ST_BUILD: begin
        ram_we = 1'b1;
        idx_d  = idx_q + 1'b1;
        if (idx_q == LAST_WORD) begin
          idx_d   = '0;
          live_d  = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_TRIG: begin
        if (trig_rsp.done) begin
          state_d = ST_RD_X;
        end
      end
      ST_RD_X: begin
        ram_raddr = {idx_q[WORD_AW-2:0], 1'b0};
        state_d   = ST_RD_Y;
      end
      ST_RD_Y: begin
        ram_raddr = {idx_q[WORD_AW-2:0], 1'b1};
        step_d    = '0;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        step_d = step_q + 1'b1;
        if (step_q == 3'd4) begin
          ram_we    = 1'b1;
          ram_waddr = {idx_q[WORD_AW-2:0], 1'b0};
          ram_wdata = nx_q;
        end else if (step_q == 3'd5) begin
          ram_we    = 1'b1;
          ram_waddr = {idx_q[WORD_AW-2:0], 1'b1};
          ram_wdata = finish(acc_q, sy_q);
          step_d    = '0;
          if (idx_q == LAST_POINT) begin
            idx_d   = '0;
            live_d  = 1'b1;
            state_d = ST_EMIT;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_RD_X;
          end
        end
      end
      ST_EMIT: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == LAST_WORD) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // rotation datapath: x' = x*c - y*s, y' = x*s + y*c
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sx_q <= shift_x_i;
      sy_q <= shift_y_i;
    end
    if (state_q == ST_TRIG && trig_rsp.done) begin
      cos_q <= trig_rsp.cos_v;
      sin_q <= trig_rsp.sin_v;
    end
    if (state_q == ST_RD_Y) begin
      x_q <= rd_word;
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_d;
      case (step_q)
        3'd0: y_q   <= rd_word;
        3'd1: acc_q <= {prod_q[63], prod_q} + HALF_LSB;
        3'd2: acc_q <= acc_q - {prod_q[63], prod_q};
        3'd3: begin
          nx_q  <= finish(acc_q, sx_q);
          acc_q <= {prod_q[63], prod_q} + HALF_LSB;
        end
        3'd4: acc_q <= acc_q + {prod_q[63], prod_q};
        default: acc_q <= acc_q;
      endcase
    end
  end

  // emit: gather four words, then strobe the segment
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      strobe_q  <= 1'b0;
    end else begin
      rd_pend_q <= state_q == ST_EMIT;
      strobe_q  <= rd_pend_q && rd_tag_q[1:0] == 2'd3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT) begin
      rd_tag_q <= idx_q;
    end
    if (rd_pend_q) begin
      case (rd_tag_q[1:0])
        2'd0:    bx_q <= rd_word;
        2'd1:    by_q <= rd_word;
        2'd2:    ex_q <= rd_word;
        default: begin
          ey_q   <= rd_word;
          seg_q  <= rd_tag_q[WORD_AW-1:2];
          last_q <= rd_tag_q[WORD_AW-1:2] == LAST_SEG;
        end
      endcase
    end
  end

  assign out_strobe_o    = strobe_q;
  assign segment_index_o = seg_q;
  assign begin_x_o       = bx_q;
  assign begin_y_o       = by_q;
  assign end_x_o         = ex_q;
  assign end_y_o         = ey_q;
  assign last_segment_o  = last_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy did not rise after a request");

  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |=> !out_strobe_o)
    else $error("result strobe held for more than one cycle");

  a_segment_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && !last_segment_o |-> ##4
      (out_strobe_o && segment_index_o == $past(segment_index_o, 4) + 4'd1))
    else $error("segments not emitted in order every four cycles");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && last_segment_o |-> !busy && segment_index_o == LAST_SEG)
    else $error("last segment out of place");

  a_trig_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig_rsp.done |-> state_q == ST_TRIG)
    else $error("CORDIC finished outside a move");

endmodule

`default_nettype wire

[rtl/cpr_ram.sv]
// ----------------------------------------------------------------------------
// cpr_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/cpr_cordic.sv]
// ----------------------------------------------------------------------------
// cpr_cordic: iterative CORDIC sine and cosine
// One rotation step per cycle with a shared shifter pair; the angle is
// folded into the right half plane and the result negated back.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_cordic
  import cpr_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cpr_trig_req_t req_i,
  output cpr_trig_rsp_t      rsp_o
);

  localparam int NSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int CW     = $clog2(NSTEPS);

  logic                 run_q;
  logic                 done_q;
  logic                 flip_q;
  logic [CW-1:0]        cnt_q;
  logic signed [33:0]   x_q, y_q;
  logic signed [32:0]   z_q;

  logic signed [33:0]   dx, dy;
  logic signed [32:0]   atan_v;
  logic signed [32:0]   z_init;
  logic                 fold_pos, fold_neg;
  logic signed [33:0]   cos_full, sin_full;

  assign dx       = y_q >>> cnt_q;
  assign dy       = x_q >>> cnt_q;
  assign atan_v   = {1'b0, atan_lut(5'(cnt_q))};
  assign fold_pos = req_i.angle > 16'sd16384;
  assign fold_neg = req_i.angle < -16'sd16384;

  always_comb begin
    z_init = {req_i.angle[15], req_i.angle, 16'h0000};
    if (fold_pos) begin
      z_init = z_init - 33'sh0_8000_0000;
    end else if (fold_neg) begin
      z_init = z_init + 33'sh0_8000_0000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
      end else if (run_q && cnt_q == CW'(NSTEPS - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q    <= GAIN_Q30;
      y_q    <= '0;
      z_q    <= z_init;
      cnt_q  <= '0;
      flip_q <= fold_pos | fold_neg;
    end else if (run_q) begin
      if (!z_q[32]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_v;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign cos_full = flip_q ? -x_q : x_q;
  assign sin_full = flip_q ? -y_q : y_q;

  assign rsp_o.done  = done_q;
  assign rsp_o.cos_v = cos_full[31:0];
  assign rsp_o.sin_v = sin_full[31:0];

endmodule

`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: command-level testbench for cross_polygon_rigid_transform
// Feeds rebuild and move requests, plus register writes between phases.
// An in-bench model of the outline (corner pattern, CORDIC sine and cosine,
// rounded rotation, saturating shift) predicts all twelve segments of every
// request. Each emitted segment is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cpr_pkg::*;

  localparam int     STEPS          = 16;
  localparam int     WATCHDOG_LIMIT = 3000;
  localparam int     TAIL_CYCLES    = 120;
  localparam int     MAX_REPORTS    = 10;
  localparam longint COORD_MAX      = 64'sd2147483647;
  localparam longint COORD_MIN      = -64'sd2147483648;
  localparam longint HALF_TURN      = 64'sd2147483648;
  localparam longint UNIT_GAIN      = 64'sd652032874;
  localparam longint ROUND_HALF     = 64'sd536870912;

  typedef enum logic [1:0] {
    OP_CMD,
    OP_CFG,
    OP_SYNC
  } op_kind_e;

  typedef struct {
    op_kind_e           kind;
    int                 idle_pct;
    cpr_cmd_e           cmd;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [15:0] angle;
    cpr_reg_e           index;
    logic [31:0]        data;
  } stim_op_t;

  typedef struct packed {
    logic [3:0]         index;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic               last;
  } segment_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic start = 1'b0;
  logic busy;
  logic command_i = 1'b0;
  logic signed [31:0] shift_x_i = '0;
  logic signed [31:0] shift_y_i = '0;
  logic signed [15:0] turn_angle_i = '0;
  logic out_strobe_o;
  logic [3:0] segment_index_o;
  logic signed [31:0] begin_x_o;
  logic signed [31:0] begin_y_o;
  logic signed [31:0] end_x_o;
  logic signed [31:0] end_y_o;
  logic last_segment_o;

  cross_polygon_rigid_transform #(
    .CORDIC_STEPS(STEPS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .shift_x_i      (shift_x_i),
    .shift_y_i      (shift_y_i),
    .turn_angle_i   (turn_angle_i),
    .out_strobe_o   (out_strobe_o),
    .segment_index_o(segment_index_o),
    .begin_x_o      (begin_x_o),
    .begin_y_o      (begin_y_o),
    .end_x_o        (end_x_o),
    .end_y_o        (end_y_o),
    .last_segment_o (last_segment_o)
  );

  // Corner pattern of the cross, one code per stored word (x, y alternating).
  cpr_corner_e corner_pat [WORD_COUNT] = '{
    CRN_MW, CRN_PL, CRN_PW, CRN_PL,  CRN_PW, CRN_PL, CRN_PW, CRN_PW,
    CRN_PW, CRN_PW, CRN_PL, CRN_PW,  CRN_PL, CRN_PW, CRN_PL, CRN_MW,
    CRN_PL, CRN_MW, CRN_PW, CRN_MW,  CRN_PW, CRN_MW, CRN_PW, CRN_ML,
    CRN_PW, CRN_ML, CRN_MW, CRN_ML,  CRN_MW, CRN_ML, CRN_MW, CRN_MW,
    CRN_MW, CRN_MW, CRN_ML, CRN_MW,  CRN_ML, CRN_MW, CRN_ML, CRN_PW,
    CRN_ML, CRN_PW, CRN_MW, CRN_PW,  CRN_MW, CRN_PW, CRN_MW, CRN_PL
  };

  // Arctangent of 2^-i in units of pi / 2^31.
  longint atan_pi31 [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41721, 20860, 10430, 5215,
    2607, 1303, 651, 325, 162, 81
  };

  int phase_idle [4] = '{0, 70, 19, 0};

  // Predicted block state.
  logic signed [31:0] half_width = '0;
  logic signed [31:0] reach = '0;
  logic signed [31:0] ctr_x = '0;
  logic signed [31:0] ctr_y = '0;
  logic signed [31:0] outline [WORD_COUNT] = '{default: '0};

  stim_op_t stim_ops [$];
  segment_t segments_due [$];
  stim_op_t in_flight;
  int idle_pct = 0;
  int hold_off = 0;
  int seg_owed = 0;
  int seg_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int rebuild_count = 0;
  int move_count = 0;
  int write_count = 0;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > COORD_MAX) return COORD_MAX[31:0];
    if (v < COORD_MIN) return COORD_MIN[31:0];
    return v[31:0];
  endfunction

  // Apply one request to the predicted outline and queue its twelve segments.
  task automatic update_outline(input stim_op_t op);
    longint   base, x, y, cs, sn, z, dx, dy;
    logic     flip;
    segment_t seg;
    if (op.cmd == CMD_REBUILD) begin
      for (int k = 0; k < WORD_COUNT; k++) begin
        case (corner_pat[k])
          CRN_PW:  base = longint'(half_width);
          CRN_MW:  base = -longint'(half_width);
          CRN_PL:  base = longint'(reach);
          default: base = -longint'(reach);
        endcase
        base = base + longint'((k % 2 == 1) ? ctr_y : ctr_x);
        outline[k] = clamp32(base);
      end
    end else begin
      z = longint'(op.angle) * 65536;
      cs = UNIT_GAIN;
      sn = 0;
      flip = 1'b0;
      // fold angles beyond a quarter turn, negate the result afterwards
      if (op.angle > 16384) begin
        z = z - HALF_TURN;
        flip = 1'b1;
      end else if (op.angle < -16384) begin
        z = z + HALF_TURN;
        flip = 1'b1;
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
        dx = sn >>> i;
        dy = cs >>> i;
        if (z >= 0) begin
          cs = cs - dx;
          sn = sn + dy;
          z = z - atan_pi31[i];
        end else begin
          cs = cs + dx;
          sn = sn - dy;
          z = z + atan_pi31[i];
        end
      end
      if (flip) begin
        cs = -cs;
        sn = -sn;
      end
      for (int k = 0; k < WORD_COUNT; k += 2) begin
        x = outline[k];
        y = outline[k + 1];
        outline[k]     = clamp32(((x * cs - y * sn + ROUND_HALF) >>> 30) + longint'(op.sx));
        outline[k + 1] = clamp32(((x * sn + y * cs + ROUND_HALF) >>> 30) + longint'(op.sy));
      end
    end
    for (int k = 0; k < SEGMENT_COUNT; k++) begin
      seg.index = 4'(k);
      seg.bx = outline[4 * k];
      seg.by = outline[4 * k + 1];
      seg.ex = outline[4 * k + 2];
      seg.ey = outline[4 * k + 3];
      seg.last = (k == SEGMENT_COUNT - 1);
      segments_due.push_back(seg);
    end
  endtask

  task automatic add_command(input cpr_cmd_e cmd, input logic signed [31:0] sx,
                             input logic signed [31:0] sy, input logic signed [15:0] angle);
    stim_op_t op;
    op.kind = OP_CMD;
    op.idle_pct = idle_pct;
    op.cmd = cmd;
    op.sx = sx;
    op.sy = sy;
    op.angle = angle;
    op.index = REG_HALF_WIDTH;
    op.data = '0;
    stim_ops.push_back(op);
  endtask

  task automatic add_write(input cpr_reg_e index, input logic [31:0] data);
    stim_op_t op;
    op.kind = OP_CFG;
    op.idle_pct = idle_pct;
    op.cmd = CMD_REBUILD;
    op.sx = '0;
    op.sy = '0;
    op.angle = '0;
    op.index = index;
    op.data = data;
    stim_ops.push_back(op);
  endtask

  task automatic add_drain_point();
    stim_op_t op;
    op.kind = OP_SYNC;
    op.idle_pct = idle_pct;
    op.cmd = CMD_REBUILD;
    op.sx = '0;
    op.sy = '0;
    op.angle = '0;
    op.index = REG_HALF_WIDTH;
    op.data = '0;
    stim_ops.push_back(op);
  endtask

  function automatic logic signed [31:0] pick_shift();
    case ($urandom_range(19))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return $urandom();
      default: return 32'(int'($urandom_range(2097151)) - 1048576);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return $urandom();
      3:       return '0;
      default: return 32'(int'($urandom_range(33554431)) - 16777216);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_angle();
    logic signed [15:0] marks [7] = '{16'sh0000, 16'sh4000, 16'shC000, 16'sh4001,
                                      16'shBFFF, 16'sh7FFF, 16'sh8000};
    if ($urandom_range(99) < 15) return marks[$urandom_range(6)];
    return 16'($urandom());
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Request driver: one op at a time, each output assigned once per edge.
  always @(posedge clk_i) begin : drive
    stim_op_t op;
    logic     nx_start;
    logic     nx_cfg_valid;
    logic     settled;
    if (rst_ni) begin
      nx_start = start;
      nx_cfg_valid = cfg_valid_i;
      if (start && !busy) begin
        update_outline(in_flight);
        seg_owed += SEGMENT_COUNT;
        if (in_flight.cmd == CMD_REBUILD) rebuild_count++;
        else move_count++;
        hold_off = ($urandom_range(99) < in_flight.idle_pct) ? $urandom_range(12, 1) : 0;
        nx_start = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_HALF_WIDTH: half_width = cfg_data_i;
          REG_REACH:      reach = cfg_data_i;
          REG_CENTER_X:   ctr_x = cfg_data_i;
          default:        ctr_y = cfg_data_i;
        endcase
        write_count++;
        nx_cfg_valid = 1'b0;
      end
      settled = (seg_owed == seg_seen) && !busy;
      if (!nx_start && !nx_cfg_valid && stim_ops.size() > 0) begin
        op = stim_ops[0];
        case (op.kind)
          OP_CMD: begin
            // count the hold-off only once the block has gone idle
            if (hold_off > 0) begin
              if (!busy) hold_off--;
            end else begin
              in_flight = stim_ops.pop_front();
              command_i <= op.cmd;
              shift_x_i <= op.sx;
              shift_y_i <= op.sy;
              turn_angle_i <= op.angle;
              nx_start = 1'b1;
            end
          end
          OP_CFG: begin
            if (settled) begin
              void'(stim_ops.pop_front());
              cfg_index_i <= op.index;
              cfg_data_i <= op.data;
              nx_cfg_valid = 1'b1;
            end
          end
          default: begin
            if (settled) void'(stim_ops.pop_front());
          end
        endcase
      end
      start <= nx_start;
      cfg_valid_i <= nx_cfg_valid;
    end
  end

  // Segment monitor: compare each strobe with the oldest prediction.
  always @(posedge clk_i) begin : collect
    segment_t got;
    segment_t want;
    if (rst_ni && out_strobe_o) begin
      got = {segment_index_o, begin_x_o, begin_y_o, end_x_o, end_y_o, last_segment_o};
      seg_seen <= seg_seen + 1;
      if (segments_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: segment %0d emitted with no request pending", $realtime, got.index);
      end else begin
        want = segments_due.pop_front();
        if (got.index !== want.index || got.bx !== want.bx || got.by !== want.by ||
            got.ex !== want.ex || got.ey !== want.ey || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: segment mismatch, expected idx %0d (%0d,%0d)-(%0d,%0d) last %0b",
                     $realtime, want.index, want.bx, want.by, want.ex, want.ey, want.last);
            $display("%0t:                   actual idx %0d (%0d,%0d)-(%0d,%0d) last %0b",
                     $realtime, got.index, got.bx, got.by, got.ex, got.ey, got.last);
          end
        end
      end
    end
  end

  // Watchdog: end the run after a long stretch with no handshake.
  always @(posedge clk_i) begin
    if ((start && !busy) || out_strobe_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d segments still due", $realtime, segments_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    // Directed: move of the all-zero reset outline, rebuild at reset settings
    add_command(CMD_MOVE, 32'sd100, -32'sd100, 16'sh1000);
    add_command(CMD_REBUILD, '0, '0, '0);
    add_write(REG_HALF_WIDTH, 32'h0001_0000);
    add_write(REG_REACH, 32'h0003_0000);
    add_write(REG_CENTER_X, 32'h0000_8000);
    add_write(REG_CENTER_Y, 32'hFFFF_0000);
    add_command(CMD_REBUILD, '0, '0, '0);
    // quarter turns, both sides of the fold, and the half turn
    add_command(CMD_MOVE, '0, '0, 16'sh0000);
    add_command(CMD_MOVE, '0, '0, 16'sh4000);
    add_command(CMD_MOVE, '0, '0, 16'shC000);
    add_command(CMD_MOVE, '0, '0, 16'sh4001);
    add_command(CMD_MOVE, '0, '0, 16'shBFFF);
    add_command(CMD_MOVE, '0, '0, 16'sh7FFF);
    add_command(CMD_MOVE, '0, '0, 16'sh8000);
    add_command(CMD_MOVE, 32'sh0123_4567, -32'sh0076_5432, 16'sh2000);
    add_command(CMD_MOVE, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh0000);
    // saturating rebuild, then rotate and shift the clipped outline
    add_write(REG_HALF_WIDTH, 32'h7FFF_FFFF);
    add_write(REG_REACH, 32'h8000_0000);
    add_write(REG_CENTER_X, 32'h7FFF_FFFF);
    add_write(REG_CENTER_Y, 32'h8000_0000);
    add_command(CMD_REBUILD, '0, '0, '0);
    add_command(CMD_MOVE, '0, '0, 16'sh8000);
    add_command(CMD_MOVE, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh0000);

    // Random phases, each with fresh settings and a drain point midway
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      add_write(REG_HALF_WIDTH, pick_coord());
      add_write(REG_REACH, pick_coord());
      add_write(REG_CENTER_X, pick_coord());
      add_write(REG_CENTER_Y, pick_coord());
      add_command(CMD_REBUILD, pick_shift(), pick_shift(), pick_angle());
      for (int n = 0; n < 24; n++) begin
        if (n == 12) add_drain_point();
        if ($urandom_range(99) < 20)
          add_command(CMD_REBUILD, pick_shift(), pick_shift(), pick_angle());
        else
          add_command(CMD_MOVE, pick_shift(), pick_shift(), pick_angle());
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (stim_ops.size() != 0 || start || cfg_valid_i || seg_owed != seg_seen || busy);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    mismatches += segments_due.size();

    $display("Checked %0d segments from %0d rebuilds and %0d moves, with %0d register writes",
             seg_seen, rebuild_count, move_count, write_count);
    $display("over four sender idle settings (0, 70, 19 and 0 percent); %0d mismatches.",
             mismatches);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
